### hw/rtl/pol_pkg.sv
package pol_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [1:0]       kind_t;
  typedef logic [1:0]       status_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  // Request kinds
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_DELETE = 2'd1;
  localparam kind_t KIND_FIND   = 2'd2;

  // Result status codes
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

### hw/rtl/pol_if.sv
interface pol_req_if;
  logic            valid;
  logic            ready;
  pol_pkg::kind_t  kind;
  pol_pkg::pos_t   position;
  pol_pkg::value_t value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pol_rsp_if;
  logic             valid;
  logic             ready;
  pol_pkg::status_t status;
  pol_pkg::pos_t    found_position;
  pol_pkg::pos_t    length;

  modport source (output valid, status, found_position, length, input ready);
  modport sink   (input valid, status, found_position, length, output ready);
endinterface

### hw/rtl/pol_ctrl.sv
module pol_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pol_pkg::cmd_t cmd
);
  import pol_pkg::*;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  // State and output-slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid;
    if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the output slot is free or drains this cycle
        if (!out_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_valid = out_valid;

endmodule

### hw/rtl/pol_dp.sv
module pol_dp (
  input  logic             clk,
  input  logic             rst,
  input  pol_pkg::cmd_t    cmd,
  input  pol_pkg::kind_t   in_kind,
  input  pol_pkg::pos_t    in_position,
  input  pol_pkg::value_t  in_value,
  output pol_pkg::status_t out_status,
  output pol_pkg::pos_t    out_found_position,
  output pol_pkg::pos_t    out_length
);
  import pol_pkg::*;

  // Captured request
  kind_t   req_kind;
  pos_t    req_pos;
  value_t  req_value;

  // List state
  count_t  count, count_next;
  value_t  entries      [CAPACITY];
  value_t  entries_next [CAPACITY];

  // Execute results
  logic [CAPACITY-1:0] match;
  status_t             st_code, st_next;

  logic [CMP_W-1:0] pos_ext, cnt_ext, slot;
  logic             ins_ok, del_ok, full, do_ins, do_del;
  logic             any_match;
  logic [IDX_W-1:0] first_idx;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= in_kind;
      req_pos   <= in_position;
      req_value <= in_value;
    end
  end

  // Range checks against the current length
  always_comb begin
    pos_ext = CMP_W'(req_pos);
    cnt_ext = CMP_W'(count);
    slot    = pos_ext - CMP_W'(1);
    full    = (cnt_ext == CMP_W'(CAPACITY));
    ins_ok  = (req_pos != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    del_ok  = (req_pos != '0) && (pos_ext <= cnt_ext);
    do_ins  = cmd.exec && (req_kind == KIND_INSERT) && ins_ok && !full;
    do_del  = cmd.exec && (req_kind == KIND_DELETE) && del_ok;

    unique case (req_kind)
      KIND_INSERT: st_next = !ins_ok ? ST_RANGE : (full ? ST_FULL : ST_DONE);
      KIND_DELETE: st_next = del_ok ? ST_DONE : ST_RANGE;
      KIND_FIND:   st_next = ST_DONE;
      default:     st_next = ST_RANGE;
    endcase

    count_next = count;
    if (do_ins) begin
      count_next = count + count_t'(1);
    end else if (do_del) begin
      count_next = count - count_t'(1);
    end
  end

  // Cell array: each cell loads from its neighbor or the new value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (CMP_W'(i) == slot) begin
          entries_next[i] = req_value;
        end else if (i > 0 && CMP_W'(i) > slot) begin
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < CAPACITY - 1 && CMP_W'(i) >= slot) begin
          entries_next[i] = entries[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Compare every live cell and hold the match vector
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_code <= st_next;
      for (int i = 0; i < CAPACITY; i++) begin
        match[i] <= (entries[i] == req_value) && (CMP_W'(i) < cnt_ext);
      end
    end
  end

  // Pick the lowest matching cell
  always_comb begin
    any_match = |match;
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_length <= POS_W'(count);
      if (req_kind == KIND_FIND) begin
        out_status         <= any_match ? ST_DONE : ST_NOTFOUND;
        out_found_position <= any_match ? POS_W'(CMP_W'(first_idx) + CMP_W'(1)) : '0;
      end else begin
        out_status         <= st_code;
        out_found_position <= '0;
      end
    end
  end

endmodule

### hw/rtl/positional_ordered_list_core.sv
// Positional ordered list of up to CAPACITY signed 32-bit values.
//
// Channels: req (sink) carries kind, position and value; rsp (source)
// carries status, found_position and length. A beat moves when valid and
// ready are both high at a rising clock edge. Every request beat yields
// exactly one response beat, in order.
//
// After the accepting edge a request passes two states: an execute state
// in which the cell array shifts for insert or delete and every cell
// compares against the search value, and a response state that encodes
// the first match and loads the output register. A new request is taken
// only after the previous one has left the response state.
//
// The output register decouples the sides: the next request is accepted
// while a response waits. If the receiver stalls, a finished response
// holds in the controller until the output register frees up, and req
// ready stays low meanwhile.
//
// Reset (rst, synchronous) empties the list; no clearing pass is needed.
module positional_ordered_list_core (
  input  logic       clk,
  input  logic       rst,
  pol_req_if.sink    req,
  pol_rsp_if.source  rsp
);
  import pol_pkg::*;

  cmd_t cmd;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  pol_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .in_kind            (req.kind),
    .in_position        (req.position),
    .in_value           (req.value),
    .out_status         (rsp.status),
    .out_found_position (rsp.found_position),
    .out_length         (rsp.length)
  );

endmodule
